// ===== hdl/slo_pkg.sv =====
`timescale 1ns / 1ps
package slo_pkg;

  localparam int MAX_LINE = 4096;
  localparam int ADDR_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int COL_W    = $clog2(MAX_LINE + 1);
  localparam int COUNT_W  = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [7:0]         NEWLINE   = 8'h0A;
  localparam logic [COL_W-1:0]   LINE_LIMIT = COL_W'(MAX_LINE);

  typedef enum logic [1:0] {
    V_SORTED   = 2'd0,
    V_UNSORTED = 2'd1,
    V_ONE_LINE = 2'd2,
    V_TOO_LONG = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_FIRST,
    PH_COMPARE,
    PH_REST,
    PH_DONE
  } phase_t;

  // one line-store access per cycle: a write at the current column and the
  // read of the column the next byte will use
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [COUNT_W-1:0] failing_line_number;
    logic [COUNT_W-1:0] line_count;
  } result_t;

endpackage

// ===== hdl/slo_ifs.sv =====
`timescale 1ns / 1ps
interface slo_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface slo_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [39:0] failing_line_number;
  logic [39:0] line_count;

  modport source (output valid, output verdict, output failing_line_number,
                  output line_count, input ready);
  modport sink   (input valid, input verdict, input failing_line_number,
                  input line_count, output ready);
endinterface

// ===== hdl/slo_ram.sv =====
`timescale 1ns / 1ps
module slo_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/slo_core.sv =====
`timescale 1ns / 1ps
module slo_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [7:0]          rd_data,
  output slo_pkg::store_req_t store_req,
  output logic                res_valid,
  output slo_pkg::result_t    res
);
  import slo_pkg::*;

  phase_t             phase, phase_next;
  logic [COL_W-1:0]   column, column_next;
  logic [COL_W-1:0]   previous_length, previous_length_next;
  logic [COUNT_W-1:0] newline_total, newline_total_next;

  logic               is_nl;
  logic               hit_limit;
  logic               col_in_prev;
  logic [COUNT_W-1:0] total_inc;
  logic signed [8:0]  sp, sc, fp, fc;
  logic               have_verdict;
  verdict_t           verdict;
  logic [COUNT_W-1:0] fail_no;

  function automatic logic signed [8:0] fold(input logic signed [8:0] v);
    logic signed [8:0] r;
    r = v;
    if (v >= 9'sd65 && v <= 9'sd90) begin
      r = v + 9'sd32;
    end
    return r;
  endfunction

  always_comb begin
    is_nl       = (data_byte == NEWLINE);
    hit_limit   = (column >= LINE_LIMIT);
    col_in_prev = (column < previous_length);
    total_inc   = (newline_total == COUNT_MAX) ? newline_total
                                               : newline_total + COUNT_W'(1);
    sp = {rd_data[7], rd_data};
    sc = {data_byte[7], data_byte};
    fp = fold(sp);
    fc = fold(sc);

    phase_next           = phase;
    column_next          = column;
    previous_length_next = previous_length;
    newline_total_next   = newline_total;
    have_verdict         = 1'b0;
    verdict              = V_SORTED;
    fail_no              = '0;
    store_req.we         = 1'b0;
    store_req.waddr      = column[ADDR_W-1:0];
    store_req.wdata      = data_byte;

    if (take) begin
      unique case (phase)
        PH_BLANK: begin
          if (is_nl) begin
            newline_total_next = total_inc;
          end else begin
            store_req.we = 1'b1;
            column_next  = COL_W'(1);
            phase_next   = PH_FIRST;
          end
        end
        PH_FIRST, PH_REST: begin
          if (is_nl) begin
            previous_length_next = column;
            column_next          = '0;
            newline_total_next   = total_inc;
            phase_next           = PH_COMPARE;
          end else if (hit_limit) begin
            have_verdict = 1'b1;
            verdict      = V_TOO_LONG;
          end else begin
            store_req.we = 1'b1;
            column_next  = column + COL_W'(1);
          end
        end
        PH_COMPARE: begin
          if (is_nl) begin
            if (col_in_prev) begin
              // current line ended first
              have_verdict       = 1'b1;
              verdict            = V_UNSORTED;
              fail_no            = newline_total;
              newline_total_next = total_inc;
            end else begin
              previous_length_next = column;
              column_next          = '0;
              newline_total_next   = total_inc;
            end
          end else if (hit_limit) begin
            have_verdict = 1'b1;
            verdict      = V_TOO_LONG;
          end else if (!col_in_prev) begin
            store_req.we = 1'b1;
            column_next  = column + COL_W'(1);
            phase_next   = PH_REST;
          end else begin
            store_req.we = 1'b1;
            column_next  = column + COL_W'(1);
            if (sp > sc) begin
              if (fp > fc) begin
                have_verdict = 1'b1;
                verdict      = V_UNSORTED;
                fail_no      = newline_total;
              end else if (fp < fc) begin
                phase_next = PH_REST;
              end
            end else if (sp < sc) begin
              phase_next = PH_REST;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (phase != PH_DONE && !have_verdict && last_byte) begin
        have_verdict = 1'b1;
        verdict      = (phase == PH_BLANK || phase == PH_FIRST) ? V_ONE_LINE : V_SORTED;
      end

      if (have_verdict && !last_byte) begin
        phase_next = PH_DONE;
      end

      if (last_byte) begin
        phase_next           = PH_BLANK;
        column_next          = '0;
        previous_length_next = '0;
        newline_total_next   = '0;
      end
    end

    res_valid               = have_verdict;
    res.verdict             = verdict;
    res.failing_line_number = fail_no;
    res.line_count          = (phase != PH_DONE && take && is_nl) ? total_inc
                                                                  : newline_total;
    store_req.raddr         = rst ? '0 : column_next[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_BLANK;
      column          <= '0;
      previous_length <= '0;
      newline_total   <= '0;
    end else begin
      phase           <= phase_next;
      column          <= column_next;
      previous_length <= previous_length_next;
      newline_total   <= newline_total_next;
    end
  end

endmodule

// ===== hdl/sorted_line_order_checker.sv =====
`timescale 1ns / 1ps
// Checks that the lines of a newline-delimited file, fed one byte per
// transaction with last_byte on the final byte, are in non-decreasing order.
// Bytes compare as signed values against the same column of the previous
// line; where the previous byte is greater the pair is compared again with
// A-Z folded to lower case. One result transaction comes per file at most:
// verdict 1 (with the previous line's number) as soon as a violation shows,
// verdict 3 for a line longer than MAX_LINE bytes, or else on the last byte
// verdict 0, or 2 when the file holds at most one line after any leading
// blank lines. After an early verdict the remaining bytes of the file are
// taken and dropped. line_count is the number of newlines seen up to the
// byte that gave the result. Throughput is one byte per clock while the
// spare register is free: the previous line sits in a single MAX_LINE-byte
// RAM with a registered read at the column the next byte will use, written
// at the current column in the same cycle. A result is registered in the
// output register, or in a spare register behind it while the output
// waits, so input flows on; input stalls only while the spare is full.
module sorted_line_order_checker (
  input  logic         clk,
  input  logic         rst,
  slo_byte_if.sink     stream,
  slo_result_if.source result
);
  import slo_pkg::*;

  logic       take;
  logic [7:0] rd_data;
  store_req_t store_req;
  logic       res_valid;
  result_t    res;

  logic       out_valid;
  result_t    out_res;
  logic       spare_valid;
  result_t    spare_res;
  logic       push;
  logic       pop;

  // a new byte is taken whenever the spare register is free
  assign stream.ready = !spare_valid;
  assign take         = stream.valid && stream.ready;
  assign push         = take && res_valid;
  assign pop          = out_valid && result.ready;

  // previous line store
  slo_ram #(
    .DEPTH (MAX_LINE),
    .WIDTH (8)
  ) u_line_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .raddr (store_req.raddr),
    .rdata (rd_data)
  );

  // per-byte compare, phase tracking and counters
  slo_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (stream.data_byte),
    .last_byte (stream.last_byte),
    .rd_data   (rd_data),
    .store_req (store_req),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register with a spare behind it; the spare is always the newer one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (spare_valid) begin
        out_res <= spare_res;
      end else if (push) begin
        out_res <= res;
      end
    end else if (push) begin
      spare_res <= res;
    end
  end

  assign result.valid               = out_valid;
  assign result.verdict             = out_res.verdict;
  assign result.failing_line_number = out_res.failing_line_number;
  assign result.line_count          = out_res.line_count;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import slo_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  // the result is registered; leave a wide margin after the last result
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 250;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int DIR_ROWS     = 30;

  // one row of the directed table: a byte repeated reps times, and where the
  // outcome is obvious the result transaction typed in by hand
  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic [15:0]        reps;
    logic               typed;
    verdict_t           verdict;
    logic [COUNT_W-1:0] fail_no;
    logic [COUNT_W-1:0] count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  slo_byte_if   stream_if ();
  slo_result_if result_if ();

  sorted_line_order_checker u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // directed files, one after another
  stim_row_t dir_rows [DIR_ROWS] = '{
    // lone byte ending the file: only one line
    '{8'h78, 1'b1, 16'd1, 1'b1, V_ONE_LINE, 40'd0, 40'd0},
    // two leading blank lines, then "b" and "a": previous line is line 3
    '{NEWLINE, 1'b0, 16'd2, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h62, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h61, 1'b0, 16'd1, 1'b1, V_UNSORTED, 40'd3, 40'd3},
    // end of file after an early verdict gives nothing
    '{NEWLINE, 1'b1, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    // signed extremes: 0x80 < 0x7f passes, 0x7f > 0xff fails
    '{8'h80, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h7F, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'hFF, 1'b0, 16'd1, 1'b1, V_UNSORTED, 40'd2, 40'd2},
    '{8'h00, 1'b1, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    // "a" then "B" passes on the case-folded compare, "bA" longer passes,
    // then "b" ends first and fails on its newline
    '{8'h61, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h42, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h62, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h41, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h62, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b1, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    // file of one blank line
    '{NEWLINE, 1'b1, 16'd1, 1'b1, V_ONE_LINE, 40'd0, 40'd1},
    // "a" then "A": equal after folding, unterminated last line, sorted
    '{8'h61, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h41, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{NEWLINE, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h41, 1'b1, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    // file ends inside the first line
    '{8'h71, 1'b0, 16'd1, 1'b0, V_SORTED, 40'd0, 40'd0},
    '{8'h72, 1'b1, 16'd1, 1'b1, V_ONE_LINE, 40'd0, 40'd0}
  };

  // ---------------------------------------------------------------------
  // line order predictor: own copy of the previous line and the counters
  // ---------------------------------------------------------------------
  logic [7:0]         prev_line_mem [MAX_LINE];
  int unsigned        prev_len;
  int unsigned        cur_col;
  phase_t             cur_phase;
  logic [COUNT_W-1:0] newlines_seen;

  function automatic void restart_file();
    cur_phase     = PH_BLANK;
    cur_col       = 0;
    prev_len      = 0;
    newlines_seen = '0;
  endfunction

  // newline counter saturates instead of wrapping
  function automatic void count_newline();
    if (newlines_seen != COUNT_MAX) newlines_seen++;
  endfunction

  function automatic void close_line();
    prev_len  = cur_col;
    cur_col   = 0;
    count_newline();
    cur_phase = PH_COMPARE;
  endfunction

  function automatic int fold_case(input int v);
    return (v >= 65 && v <= 90) ? v + 32 : v;
  endfunction

  // takes one byte; returns 1 with the result transaction if it causes one
  function automatic bit order_verdict(input logic [7:0] b, input logic last,
                                       output result_t r);
    phase_t             entry;
    int                 vd;
    logic [COUNT_W-1:0] fail_no;
    int                 sp;
    int                 sc;
    entry   = cur_phase;
    vd      = -1;
    fail_no = '0;
    r       = '0;
    case (cur_phase)
      PH_BLANK: begin
        if (b == NEWLINE) begin
          count_newline();
        end else begin
          prev_line_mem[0] = b;
          cur_col          = 1;
          cur_phase        = PH_FIRST;
        end
      end
      PH_FIRST, PH_REST: begin
        if (b == NEWLINE) begin
          close_line();
        end else if (cur_col >= MAX_LINE) begin
          vd = V_TOO_LONG;
        end else begin
          prev_line_mem[cur_col] = b;
          cur_col++;
        end
      end
      PH_COMPARE: begin
        if (b == NEWLINE) begin
          // current line ends first: the newline still counts
          if (cur_col < prev_len) begin
            vd      = V_UNSORTED;
            fail_no = newlines_seen;
            count_newline();
          end else begin
            close_line();
          end
        end else if (cur_col >= MAX_LINE) begin
          vd = V_TOO_LONG;
        end else if (cur_col >= prev_len) begin
          // previous line was shorter: passed
          prev_line_mem[cur_col] = b;
          cur_col++;
          cur_phase = PH_REST;
        end else begin
          sp = int'($signed(prev_line_mem[cur_col]));
          sc = int'($signed(b));
          prev_line_mem[cur_col] = b;
          cur_col++;
          if (sp > sc) begin
            if (fold_case(sp) > fold_case(sc)) begin
              vd      = V_UNSORTED;
              fail_no = newlines_seen;
            end else if (fold_case(sp) < fold_case(sc)) begin
              cur_phase = PH_REST;
            end
          end else if (sp < sc) begin
            cur_phase = PH_REST;
          end
        end
      end
      default: begin
        // early verdict given: drop bytes up to the end of the file
        if (last) restart_file();
        return 1'b0;
      end
    endcase
    if (vd < 0 && last) begin
      vd = (entry == PH_BLANK || entry == PH_FIRST) ? V_ONE_LINE : V_SORTED;
    end
    if (vd < 0) return 1'b0;
    r.verdict             = verdict_t'(vd);
    r.failing_line_number = (vd == V_UNSORTED) ? fail_no : '0;
    r.line_count          = newlines_seen;
    if (last) restart_file();
    else cur_phase = PH_DONE;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus state and bookkeeping
  // ---------------------------------------------------------------------
  result_t    pending_verdicts [$];
  logic [7:0] file_bytes [$];
  logic [7:0] prev_text [$];
  logic [7:0] cur_text [$];
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_req;
  bit         use_typed;
  result_t    typed_result;
  int         bytes_sent;
  int         files_sent;
  int         results_predicted;
  int         verdicts_checked;
  int         mismatches;
  int         verdict_hits [4];

  // printable letters of both cases are favored so the folded compare fires
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1:    c = 8'($urandom_range(65, 90));
      2, 3:    c = 8'($urandom_range(97, 122));
      default: c = 8'($urandom_range(255));
    endcase
    if (c == NEWLINE) c = 8'h0B;
    return c;
  endfunction

  // one byte transaction; the predictor runs once acceptance is certain
  // (ready seen at the falling edge holds through the next rising edge)
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.data_byte <= b;
    stream_if.last_byte <= last;
    @(negedge clk);
    while (!stream_if.ready) @(negedge clk);
    if (order_verdict(b, last, r)) begin
      pending_verdicts.push_back(use_typed ? typed_result : r);
      results_predicted++;
    end
    bytes_sent++;
    @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[n]) send_byte(file_bytes[n], n == file_bytes.size() - 1);
    files_sent++;
  endtask

  // sender goes quiet until every result is in and the pipe has drained
  task automatic settle();
    stream_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random file: mostly each line built from the one before so that files
  // get past many lines, with some broken lines and some pure noise
  task automatic build_file();
    int n_lines;
    int kind;
    int k;
    int v;
    int sp;
    int i;
    int j;
    file_bytes.delete();
    prev_text.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) begin
        file_bytes.push_back(($urandom_range(6) == 0) ? NEWLINE : text_byte());
      end
      return;
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) file_bytes.push_back(NEWLINE);
    end
    n_lines = $urandom_range(1, 10);
    for (i = 0; i < n_lines; i++) begin
      cur_text.delete();
      kind = (i == 0) ? 99 : $urandom_range(99);
      if (kind < 40) begin
        // previous line plus a tail: equal or longer, passes
        cur_text = prev_text;
        repeat ($urandom_range(4)) cur_text.push_back(text_byte());
      end else if (kind < 85 && prev_text.size() > 0) begin
        // common prefix, then one deciding byte
        k = $urandom_range(prev_text.size() - 1);
        for (j = 0; j < k; j++) cur_text.push_back(prev_text[j]);
        sp = int'($signed(prev_text[k]));
        if (kind < 70) begin
          v = (sp < 127) ? sp + 1 + $urandom_range(126 - sp) : sp;
        end else if (prev_text[k] >= 8'd97 && prev_text[k] <= 8'd122 &&
                     $urandom_range(1) == 1) begin
          v = $urandom_range(65, 90);
        end else begin
          v = (sp > -128) ? sp - 1 - $urandom_range(sp + 127) : sp;
        end
        if (v[7:0] == NEWLINE) v = sp;
        cur_text.push_back(v[7:0]);
        repeat ($urandom_range(4)) cur_text.push_back(text_byte());
      end else begin
        repeat ((i == 0) ? $urandom_range(1, 8) : $urandom_range(8)) begin
          cur_text.push_back(text_byte());
        end
      end
      for (j = 0; j < cur_text.size(); j++) file_bytes.push_back(cur_text[j]);
      // last line is sometimes left without its newline
      if (i < n_lines - 1 || cur_text.size() == 0 || $urandom_range(1) == 1) begin
        file_bytes.push_back(NEWLINE);
      end
      prev_text = cur_text;
    end
    if (file_bytes.size() == 0) file_bytes.push_back(8'h78);
  endtask

  task automatic run_random_phase(input int budget, input int until_results);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget || results_predicted < until_results) begin
      build_file();
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    stream_if.valid     = 1'b0;
    stream_if.data_byte = 8'h00;
    stream_if.last_byte = 1'b0;
    rst                 = 1'b1;
    hold_req            = 1'b0;
    use_typed           = 1'b0;
    typed_result        = '0;
    bytes_sent          = 0;
    files_sent          = 0;
    results_predicted   = 0;
    verdicts_checked    = 0;
    mismatches          = 0;
    foreach (verdict_hits[n]) verdict_hits[n] = 0;
    // first setting: sender idles less than the receiver
    send_idle_pct       = 36;
    recv_idle_pct       = 58;
    restart_file();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table; typed rows replace the predicted transaction
    foreach (dir_rows[n]) begin
      use_typed                        = dir_rows[n].typed;
      typed_result.verdict             = dir_rows[n].verdict;
      typed_result.failing_line_number = dir_rows[n].fail_no;
      typed_result.line_count          = dir_rows[n].count;
      repeat (dir_rows[n].reps) send_byte(dir_rows[n].data, dir_rows[n].last);
    end
    use_typed = 1'b0;
    settle();

    run_random_phase(PHASE_BYTES, 0);
    settle();

    // second setting: roles swapped
    send_idle_pct = 58;
    recv_idle_pct = 36;

    run_random_phase(PHASE_BYTES, 0);
    settle();

    // third setting: no idling; receiver holds off at the start while
    // single-byte files pile results up against the output register
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (8) begin
      file_bytes = '{text_byte()};
      send_file();
    end
    run_random_phase(PHASE_BYTES, 0);
    settle();

    $display("checked %0d result transactions from %0d files, %0d bytes",
             verdicts_checked, files_sent, bytes_sent);
    $display("verdicts: sorted %0d, unsorted %0d, one line %0d, too long %0d",
             verdict_hits[V_SORTED], verdict_hits[V_UNSORTED],
             verdict_hits[V_ONE_LINE], verdict_hits[V_TOO_LONG]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random back-pressure, or a long hold counted here
  initial begin
    int hold_left;
    hold_left       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker: sampled at the falling edge, away from the drive edge
  always @(negedge clk) begin
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none expected, verdict %0d line_count %0d",
                 $time, result_if.verdict, result_if.line_count);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        verdict_hits[want.verdict]++;
        if (result_if.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d actual %0d",
                   $time, want.verdict, result_if.verdict);
          mismatches++;
        end
        if (result_if.failing_line_number !== want.failing_line_number) begin
          $display("%0t: failing_line_number expected %0d actual %0d",
                   $time, want.failing_line_number, result_if.failing_line_number);
          mismatches++;
        end
        if (result_if.line_count !== want.line_count) begin
          $display("%0t: line_count expected %0d actual %0d",
                   $time, want.line_count, result_if.line_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results outstanding", pending_verdicts.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
